FILE: hw/rtl/pds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

  localparam int unsigned PIX_W    = 16;
  localparam int unsigned ADDR_W   = 21;
  localparam int unsigned SIZE_W   = 10;
  localparam int unsigned STRIDE_W = 11;
  localparam int unsigned OFFS_W   = 20;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  // Reciprocal of three in 9 fractional bits; exact for dividends below 512.
  localparam logic [8:0] RECIP3 = 9'd171;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_ROWS   = 2'd1,
    MODE_GRID   = 2'd2,
    MODE_STRIPE = 2'd3
  } pds_mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE         = 2'd0,
    REG_HALF_WIDTH   = 2'd1,
    REG_HALF_HEIGHT  = 2'd2,
    REG_START_OFFSET = 2'd3
  } pds_reg_e;

  typedef struct packed {
    pds_mode_e          mode;
    logic [SIZE_W-1:0]  width;   // clamped to [1, max]
    logic [SIZE_W-1:0]  height;  // clamped to [1, max]
    logic [OFFS_W-1:0]  start_offset;
  } pds_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [STRIDE_W-1:0] stride;
    logic [PIX_W-1:0]    pixel;
    logic [PIX_W-1:0]    dark;
    pds_mode_e           mode;
    logic                frame_end;
  } pds_item_t;

  // Two thirds of an 8-bit channel value, given as twice the value.
  function automatic logic [7:0] third_of(input logic [8:0] x);
    logic [17:0] prod;
    prod = x * RECIP3;
    return prod[16:9];
  endfunction

  function automatic logic [PIX_W-1:0] darken(input logic [PIX_W-1:0] p);
    logic [7:0] r2;
    logic [7:0] g2;
    logic [7:0] b2;
    r2 = third_of({p[15:11], 4'b0000});
    g2 = third_of({p[10:5], 3'b000});
    b2 = third_of({p[4:0], 4'b0000});
    return {r2[7:3], g2[7:2], b2[7:3]};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pds_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_cfg #(
  parameter int unsigned MAX_HALF_WIDTH  = 512,
  parameter int unsigned MAX_HALF_HEIGHT = 512
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [pds_pkg::IDX_W-1:0] cfg_index_i,
  input  wire logic [pds_pkg::CFG_W-1:0] cfg_data_i,
  output pds_pkg::pds_cfg_t              cfg_o
);
  import pds_pkg::*;

  localparam logic [SIZE_W-1:0] MaxW = SIZE_W'(MAX_HALF_WIDTH);
  localparam logic [SIZE_W-1:0] MaxH = SIZE_W'(MAX_HALF_HEIGHT);

  pds_mode_e          mode_q;
  logic [SIZE_W-1:0]  half_width_q;
  logic [SIZE_W-1:0]  half_height_q;
  logic [OFFS_W-1:0]  start_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_ROWS;
      half_width_q   <= SIZE_W'(160);
      half_height_q  <= SIZE_W'(120);
      start_offset_q <= '0;
    end else if (cfg_we_i) begin
      case (pds_reg_e'(cfg_index_i))
        REG_MODE:         mode_q         <= pds_mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_HALF_WIDTH:   half_width_q   <= cfg_data_i[SIZE_W-1:0];
        REG_HALF_HEIGHT:  half_height_q  <= cfg_data_i[SIZE_W-1:0];
        REG_START_OFFSET: start_offset_q <= cfg_data_i[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.mode         = mode_q;
    cfg_o.start_offset = start_offset_q;
    if (half_width_q == '0) begin
      cfg_o.width = SIZE_W'(1);
    end else if (half_width_q > MaxW) begin
      cfg_o.width = MaxW;
    end else begin
      cfg_o.width = half_width_q;
    end
    if (half_height_q == '0) begin
      cfg_o.height = SIZE_W'(1);
    end else if (half_height_q > MaxH) begin
      cfg_o.height = MaxH;
    end else begin
      cfg_o.height = half_height_q;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pds_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_front #(
  parameter int unsigned MAX_HALF_WIDTH  = 512,
  parameter int unsigned MAX_HALF_HEIGHT = 512
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  pds_pkg::pds_cfg_t              cfg_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [pds_pkg::PIX_W-1:0] pixel_i,
  input  wire logic                      item_pop_i,
  output logic                           item_valid_o,
  output pds_pkg::pds_item_t             item_o
);
  import pds_pkg::*;

  localparam int unsigned ColW = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
  localparam int unsigned RowW = (MAX_HALF_HEIGHT > 1) ? $clog2(MAX_HALF_HEIGHT) : 1;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            item_valid_q;
  pds_item_t       item_q;
  logic            accept;
  logic            col_end;
  logic            row_end;
  logic [RowW+SIZE_W-1:0] row_prod;
  logic [ADDR_W-1:0]      base;

  assign s_axis_tready = !item_valid_q || item_pop_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // A counter left beyond a shrunken size still counts as the end.
  assign col_end = SIZE_W'(col_q) >= (cfg_i.width - SIZE_W'(1));
  assign row_end = SIZE_W'(row_q) >= (cfg_i.height - SIZE_W'(1));

  assign row_prod = row_q * cfg_i.width;
  assign base = ADDR_W'(cfg_i.start_offset) + ADDR_W'({row_prod, 2'b00})
              + ADDR_W'({col_q, 1'b0});

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : RowW'(row_q + RowW'(1));
    end else begin
      col_d = ColW'(col_q + ColW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      item_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q        <= col_d;
        row_q        <= row_d;
        item_valid_q <= 1'b1;
      end else if (item_pop_i) begin
        item_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.base      <= base;
      item_q.stride    <= {cfg_i.width, 1'b0};
      item_q.pixel     <= pixel_i;
      item_q.dark      <= darken(pixel_i);
      item_q.mode      <= cfg_i.mode;
      item_q.frame_end <= col_end && row_end;
    end
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pds_out.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_out (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            item_valid_i,
  input  pds_pkg::pds_item_t                   item_i,
  output logic                                 item_pop_o,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [pds_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tuser
);
  import pds_pkg::*;

  logic [1:0]        beat_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PIX_W-1:0]  color_q, color_d;
  logic              last_q;
  logic              frame_end_q;
  logic              load;
  logic              use_dark;

  // Beats go top-left, top-right, bottom-left, bottom-right.
  assign load       = item_valid_i && (!out_valid_q || m_axis_tready);
  assign item_pop_o = load && (beat_q == 2'd3);

  always_comb begin
    case (item_i.mode)
      MODE_PLAIN:  use_dark = 1'b0;
      MODE_ROWS:   use_dark = beat_q[1];
      MODE_GRID:   use_dark = (beat_q != 2'd0);
      MODE_STRIPE: use_dark = beat_q[0];
      default:     use_dark = 1'b0;
    endcase
    color_d = use_dark ? item_i.dark : item_i.pixel;
    addr_d  = item_i.base + (beat_q[1] ? ADDR_W'(item_i.stride) : '0)
            + ADDR_W'(beat_q[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        beat_q      <= beat_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q      <= addr_d;
      color_q     <= color_d;
      last_q      <= (beat_q == 2'd3);
      frame_end_q <= item_i.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - ADDR_W - PIX_W)'(0), color_q, addr_q};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = frame_end_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pixel_doubler_scanline.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tdata[15:0] source pixel, RGB565
// m_axis    out        tdata address, color; tlast block end; tuser frame end
// cfg       in         mode, half_width, half_height, start_offset by index
//
// Each source pixel produces four words, one per cycle while the output is
// not stalled; the output beat sequencer takes a new pixel as it loads the
// last word. A pixel is held in the item register, then the output register.
// Reset clears the row and column counters and loads the register defaults.
// A stalled output holds its word; the next pixel is taken while the last
// word of the current block waits to be taken.

module pixel_doubler_scanline #(
  parameter int unsigned MAX_HALF_WIDTH  = 512,
  parameter int unsigned MAX_HALF_HEIGHT = 512
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [pds_pkg::PIX_W-1:0]       s_axis_tdata,   // pixel
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [pds_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // address, color
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tuser,   // frame_end
  input  wire logic                            cfg_we_i,
  input  wire logic [pds_pkg::IDX_W-1:0]       cfg_index_i,
  input  wire logic [pds_pkg::CFG_W-1:0]       cfg_data_i
);
  import pds_pkg::*;

  pds_cfg_t  cfg;
  pds_item_t item;
  logic      item_valid;
  logic      item_pop;

  pds_cfg #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .MAX_HALF_HEIGHT(MAX_HALF_HEIGHT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pds_front #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .MAX_HALF_HEIGHT(MAX_HALF_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .pixel_i      (s_axis_tdata),
    .item_pop_i   (item_pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  pds_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: tb/sv/pixel_doubler_scanline_tb.sv
`timescale 1ns / 1ps

module pixel_doubler_scanline_tb;
  import pds_pkg::*;

  localparam int          RESET_CYCLES  = 10;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int unsigned MAX_SIZE      = 512;
  localparam int          RANDOM_ITEMS  = 176;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PRESSURE_ITEMS = 24;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [PIX_W-1:0]  color;
    logic              last;
    logic              frame_end;
  } out_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata;    // pixel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;    // address [20:0], color [36:21]
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;    // frame_end
  logic                   cfg_we_i;
  logic [IDX_W-1:0]       cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;

  pixel_doubler_scanline dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the registers and the source position counters.
  pds_mode_e         sh_mode;
  logic [SIZE_W-1:0] sh_width;
  logic [SIZE_W-1:0] sh_height;
  logic [OFFS_W-1:0] sh_offset;
  logic [8:0]        src_col;
  logic [8:0]        src_row;

  out_word_t   pending_words[$];
  out_word_t   want;
  int          error_count = 0;
  int unsigned cycle_count = 0;
  bit          full_rate = 1'b0;
  bit          hold_off_req = 1'b0;

  function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIZE) return MAX_SIZE;
    return v;
  endfunction

  // Blend 2:1 with black per channel at 8-bit precision, then truncate back.
  function automatic logic [PIX_W-1:0] dim_pixel(input logic [PIX_W-1:0] p);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    r = (2 * {p[15:11], 3'b000}) / 3;
    g = (2 * {p[10:5], 2'b00}) / 3;
    b = (2 * {p[4:0], 3'b000}) / 3;
    return PIX_W'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hF8) >> 3));
  endfunction

  task automatic predict_block_words(input logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned stride;
    int unsigned base;
    logic [PIX_W-1:0] dark;
    logic [PIX_W-1:0] colors[4];
    bit col_end;
    bit row_end;
    out_word_t word;
    w = clamp_dim(sh_width);
    h = clamp_dim(sh_height);
    stride = 2 * w;
    base = sh_offset + 2 * src_row * stride + 2 * src_col;
    col_end = (src_col >= w - 1);
    row_end = (src_row >= h - 1);
    dark = dim_pixel(px);
    case (sh_mode)
      MODE_PLAIN:  colors = '{px, px, px, px};
      MODE_ROWS:   colors = '{px, px, dark, dark};
      MODE_GRID:   colors = '{px, dark, dark, dark};
      default:     colors = '{px, dark, px, dark};
    endcase
    // Order: top-left, top-right, bottom-left, bottom-right.
    for (int k = 0; k < 4; k++) begin
      word.address = ADDR_W'(base + ((k >= 2) ? stride : 0) + (k % 2));
      word.color = colors[k];
      word.last = (k == 3);
      word.frame_end = col_end && row_end;
      pending_words.push_back(word);
    end
    if (col_end) begin
      src_col = '0;
      src_row = row_end ? 9'd0 : src_row + 9'd1;
    end else begin
      src_col = src_col + 9'd1;
    end
  endtask

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'(MAX_SIZE);
      3:       return SIZE_W'($urandom_range(MAX_SIZE + 1, 1023));
      default: return SIZE_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [OFFS_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return OFFS_W'($urandom());
  endfunction

  task automatic put_reg(input pds_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Only called with the block idle; the counters are deliberately left alone.
  task automatic program_regs(input pds_mode_e m, input logic [SIZE_W-1:0] hw,
                              input logic [SIZE_W-1:0] hh, input logic [OFFS_W-1:0] offs);
    put_reg(REG_MODE, CFG_W'(m));
    put_reg(REG_HALF_WIDTH, CFG_W'(hw));
    put_reg(REG_HALF_HEIGHT, CFG_W'(hh));
    put_reg(REG_START_OFFSET, CFG_W'(offs));
    cfg_we_i <= 1'b0;
    sh_mode = m;
    sh_width = hw;
    sh_height = hh;
    sh_offset = offs;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = 0;
    if (!full_rate && $urandom_range(0, 3) == 0) gap = pick_idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_block_words(px);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    logic [PIX_W-1:0] pixels[7];
    pixels = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hAAAA, 16'h5555};
    foreach (pixels[i]) send_pixel(pixels[i]);
    wait_idle();
  endtask

  task automatic test_each_mode();
    pds_mode_e modes[4];
    modes = '{MODE_PLAIN, MODE_ROWS, MODE_GRID, MODE_STRIPE};
    foreach (modes[i]) begin
      program_regs(modes[i], 10'd4, 10'd3, OFFS_W'(i * 1000));
      send_pixel(16'hFFFF);
      send_pixel(pick_pixel());
      wait_idle();
    end
  endtask

  // The counters still hold a large column, so the first pixel wraps early.
  task automatic test_frame_wrap();
    program_regs(MODE_GRID, 10'd2, 10'd2, 20'h00010);
    repeat (6) send_pixel(pick_pixel());
    wait_idle();
  endtask

  task automatic test_size_saturation();
    program_regs(MODE_STRIPE, 10'd0, 10'd0, 20'hFFFFF);
    repeat (2) send_pixel(pick_pixel());
    wait_idle();
    program_regs(MODE_ROWS, 10'd1023, 10'd1023, 20'hABCDE);
    repeat (2) send_pixel(pick_pixel());
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      full_rate = (phase == 3);
      program_regs(pds_mode_e'($urandom_range(0, 3)), pick_size(), pick_size(),
                   pick_offset());
      repeat (RANDOM_ITEMS / RANDOM_PHASES) send_pixel(pick_pixel());
      wait_idle();
      full_rate = 1'b0;
    end
  endtask

  // The receiver holds off for a long time while pixels keep coming.
  task automatic test_backpressure();
    program_regs(MODE_GRID, 10'd5, 10'd4, pick_offset());
    hold_off_req = 1'b1;
    repeat (PRESSURE_ITEMS) send_pixel(pick_pixel());
    wait_idle();
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        if (stall_left == 0 && !full_rate && $urandom_range(0, 5) == 0)
          stall_left = pick_idle_len();
        if (stall_left > 0 && !full_rate) begin
          m_axis_tready <= 1'b0;
          stall_left--;
        end else begin
          stall_left = 0;
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: tdata=%h tlast=%b tuser=%b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata[ADDR_W-1:0] !== want.address) begin
          $error("address: expected %h, got %h", want.address, m_axis_tdata[ADDR_W-1:0]);
          error_count++;
        end
        if (m_axis_tdata[ADDR_W +: PIX_W] !== want.color) begin
          $error("color: expected %h, got %h", want.color, m_axis_tdata[ADDR_W +: PIX_W]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_axis_tlast);
          error_count++;
        end
        if (m_axis_tuser !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("pixel_doubler_scanline_tb: FAIL");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_MODE;
    cfg_data_i <= '0;
    sh_mode = MODE_ROWS;
    sh_width = 10'd160;
    sh_height = 10'd120;
    sh_offset = '0;
    src_col = '0;
    src_row = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_each_mode();
    test_frame_wrap();
    test_size_saturation();
    test_random_traffic();
    test_backpressure();

    if (error_count == 0) begin
      $display("pixel_doubler_scanline_tb: PASS");
    end else begin
      $display("pixel_doubler_scanline_tb: FAIL");
    end
    $finish;
  end

endmodule
